[rtl/core/hsvc_pkg.sv]
// Shared formats, constants and item types of the HSV to RGB converter.
package hsvc_pkg;

  localparam int LEVEL_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS   = 4;

  localparam int HUE_W  = 16;
  localparam int LVL_W  = LEVEL_FRAC_BITS + 1;
  localparam int LVL_ONE = 2 ** LEVEL_FRAC_BITS;

  localparam int HUE_SECTOR = 60 * (2 ** HUE_FRAC_BITS);
  localparam int HUE_TURN   = 6 * HUE_SECTOR;

  // smallest multiple of a turn that lifts every hue to a non-negative value
  localparam int HUE_OFFSET = HUE_TURN * (((2 ** (HUE_W - 1)) + HUE_TURN - 1) / HUE_TURN);
  localparam int WRAP_W     = $clog2((2 ** (HUE_W - 1)) + HUE_OFFSET);
  localparam int TURN_RECIP = (2 ** WRAP_W) / HUE_TURN;
  localparam int TR_W       = $clog2(TURN_RECIP + 1);
  localparam int QUO_W      = $clog2(TURN_RECIP + 1);
  localparam int REM_W      = $clog2(2 * HUE_TURN);
  localparam int HW_W       = $clog2(HUE_TURN);
  localparam int T_W        = $clog2(HUE_SECTOR + 1);

  localparam int PROD_W     = 2 * LVL_W;
  localparam int CX_W       = $clog2(LVL_ONE * HUE_SECTOR + HUE_SECTOR / 2 + 1);
  localparam int SEC_RECIP  = (2 ** CX_W) / HUE_SECTOR;
  localparam int SR_W       = $clog2(SEC_RECIP + 1);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [LVL_W-1:0]        saturation;
    logic [LVL_W-1:0]        brightness;
  } hsv_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    sector_t          sector;
    logic [T_W-1:0]   t;
    logic [LVL_W-1:0] chroma;
    logic [LVL_W-1:0] m;
  } mid_t;

endpackage

[rtl/core/hsv_to_rgb_converter.sv]
// HSV to RGB converter top level: nine-stage pipeline with a shared stall.
//
//  channel | dir | handshake            | item
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid / in_stall  | hsv_t: hue, saturation, brightness
//  out     | out | out_valid / out_stall| rgb_t: red, green, blue
//
// One item per cycle while no stalled result is held; each result passes through
// nine register stages.
// Depth comes from the hue wrap and the divide by a sector, both done as
// reciprocal multiply and one-step correction over separate stages.
// Reset (rst_n low, synchronous) clears the valid bits only.
// A stalled result freezes every stage; in_stall rises in that same cycle.
module hsv_to_rgb_converter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hsvc_pkg::hsv_t  in_pixel,
  output logic           out_valid,
  input  logic           out_stall,
  output hsvc_pkg::rgb_t  out_pixel
);
  import hsvc_pkg::*;

  logic en;
  logic mid_valid;
  mid_t mid;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  hsvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_pixel  (in_pixel),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  hsvc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mid_valid (mid_valid),
    .mid       (mid),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

endmodule

[rtl/core/hsvc_front.sv]
// Front pipeline: level clamp, chroma product, hue wrap, sector and offset.
module hsvc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  hsvc_pkg::hsv_t in_pixel,
  output logic          mid_valid,
  output hsvc_pkg::mid_t mid
);
  import hsvc_pkg::*;

  localparam int QP_W = WRAP_W + TR_W;

  logic [4:0] vld_r;

  // stage 1
  logic [WRAP_W-1:0] u1_r, u1_nxt;
  logic [LVL_W-1:0]  s1_r, s1_nxt, v1_r, v1_nxt;
  // stage 2
  logic [QP_W-1:0]   qprod;
  logic [QUO_W-1:0]  qe2_r, qe2_nxt;
  logic [WRAP_W-1:0] u2_r;
  logic [PROD_W-1:0] p2_r, p2_nxt;
  logic [LVL_W-1:0]  v2_r;
  // stage 3
  logic [REM_W-1:0]  r3_r, r3_nxt;
  logic [LVL_W-1:0]  c3_r, c3_nxt, v3_r;
  // stage 4
  logic [HW_W-1:0]   hw4_r, hw4_nxt;
  logic [LVL_W-1:0]  c4_r, m4_r, m4_nxt;
  // stage 5
  sector_t           sec5_r, sec5_nxt;
  logic [T_W-1:0]    t5_r, t5_nxt;
  logic [LVL_W-1:0]  c5_r, m5_r;
  logic [HW_W-1:0]   base, f;

  always_comb begin
    u1_nxt = WRAP_W'(in_pixel.hue) + WRAP_W'(HUE_OFFSET);
    s1_nxt = (in_pixel.saturation > LVL_W'(LVL_ONE)) ? LVL_W'(LVL_ONE) : in_pixel.saturation;
    v1_nxt = (in_pixel.brightness > LVL_W'(LVL_ONE)) ? LVL_W'(LVL_ONE) : in_pixel.brightness;

    qprod   = QP_W'(u1_r) * QP_W'(TURN_RECIP);
    qe2_nxt = QUO_W'(qprod >> WRAP_W);
    p2_nxt  = PROD_W'(v1_r) * PROD_W'(s1_r);

    r3_nxt = REM_W'(u2_r - (WRAP_W'(qe2_r) * WRAP_W'(HUE_TURN)));
    c3_nxt = LVL_W'((p2_r + PROD_W'(LVL_ONE / 2)) >> LEVEL_FRAC_BITS);

    hw4_nxt = (r3_r >= REM_W'(HUE_TURN)) ? HW_W'(r3_r - REM_W'(HUE_TURN)) : HW_W'(r3_r);
    m4_nxt  = v3_r - c3_r;

    priority if (hw4_r >= HW_W'(5 * HUE_SECTOR)) begin
      sec5_nxt = SEC_MAG_RED;
      base     = HW_W'(5 * HUE_SECTOR);
    end else if (hw4_r >= HW_W'(4 * HUE_SECTOR)) begin
      sec5_nxt = SEC_BLU_MAG;
      base     = HW_W'(4 * HUE_SECTOR);
    end else if (hw4_r >= HW_W'(3 * HUE_SECTOR)) begin
      sec5_nxt = SEC_CYN_BLU;
      base     = HW_W'(3 * HUE_SECTOR);
    end else if (hw4_r >= HW_W'(2 * HUE_SECTOR)) begin
      sec5_nxt = SEC_GRN_CYN;
      base     = HW_W'(2 * HUE_SECTOR);
    end else if (hw4_r >= HW_W'(HUE_SECTOR)) begin
      sec5_nxt = SEC_YEL_GRN;
      base     = HW_W'(HUE_SECTOR);
    end else begin
      sec5_nxt = SEC_RED_YEL;
      base     = '0;
    end
    f = hw4_r - base;
    // falling edge of the ramp in odd sectors
    t5_nxt = sec5_nxt[0] ? (T_W'(HUE_SECTOR) - T_W'(f)) : T_W'(f);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u1_nxt;
      s1_r   <= s1_nxt;
      v1_r   <= v1_nxt;
      qe2_r  <= qe2_nxt;
      u2_r   <= u1_r;
      p2_r   <= p2_nxt;
      v2_r   <= v1_r;
      r3_r   <= r3_nxt;
      c3_r   <= c3_nxt;
      v3_r   <= v2_r;
      hw4_r  <= hw4_nxt;
      c4_r   <= c3_r;
      m4_r   <= m4_nxt;
      sec5_r <= sec5_nxt;
      t5_r   <= t5_nxt;
      c5_r   <= c4_r;
      m5_r   <= m4_r;
    end
  end

  assign mid_valid  = vld_r[4];
  assign mid.sector = sec5_r;
  assign mid.t      = t5_r;
  assign mid.chroma = c5_r;
  assign mid.m      = m5_r;

endmodule

[rtl/core/hsvc_back.sv]
// Back pipeline: X by reciprocal division, sector placement, offset add.
module hsvc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           mid_valid,
  input  hsvc_pkg::mid_t  mid,
  output logic           out_valid,
  output hsvc_pkg::rgb_t  out_pixel
);
  import hsvc_pkg::*;

  localparam int XP_W = CX_W + SR_W;

  logic [3:0] vld_r;

  // stage 6
  logic [CX_W-1:0]  cx6_r, cx6_nxt;
  sector_t          sec6_r, sec7_r, sec8_r;
  logic [LVL_W-1:0] c6_r, c7_r, c8_r;
  logic [LVL_W-1:0] m6_r, m7_r, m8_r;
  // stage 7
  logic [XP_W-1:0]  xprod;
  logic [LVL_W-1:0] xe7_r, xe7_nxt;
  logic [CX_W-1:0]  cx7_r;
  // stage 8
  logic [CX_W-1:0]  rem;
  logic [LVL_W-1:0] x8_r, x8_nxt;
  // stage 9
  logic [LVL_W-1:0] r_sel, g_sel, b_sel;
  rgb_t             pix9_r, pix9_nxt;

  always_comb begin
    cx6_nxt = (CX_W'(mid.chroma) * CX_W'(mid.t)) + CX_W'(HUE_SECTOR / 2);

    // estimate is exact or one low
    xprod   = XP_W'(cx6_r) * XP_W'(SEC_RECIP);
    xe7_nxt = LVL_W'(xprod >> CX_W);

    rem    = cx7_r - (CX_W'(xe7_r) * CX_W'(HUE_SECTOR));
    x8_nxt = (rem >= CX_W'(HUE_SECTOR)) ? (xe7_r + LVL_W'(1)) : xe7_r;

    unique case (sec8_r)
      SEC_RED_YEL: begin r_sel = c8_r; g_sel = x8_r; b_sel = '0;   end
      SEC_YEL_GRN: begin r_sel = x8_r; g_sel = c8_r; b_sel = '0;   end
      SEC_GRN_CYN: begin r_sel = '0;   g_sel = c8_r; b_sel = x8_r; end
      SEC_CYN_BLU: begin r_sel = '0;   g_sel = x8_r; b_sel = c8_r; end
      SEC_BLU_MAG: begin r_sel = x8_r; g_sel = '0;   b_sel = c8_r; end
      default:     begin r_sel = c8_r; g_sel = '0;   b_sel = x8_r; end
    endcase
    pix9_nxt.red   = r_sel + m8_r;
    pix9_nxt.green = g_sel + m8_r;
    pix9_nxt.blue  = b_sel + m8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx6_r  <= cx6_nxt;
      sec6_r <= mid.sector;
      c6_r   <= mid.chroma;
      m6_r   <= mid.m;
      xe7_r  <= xe7_nxt;
      cx7_r  <= cx6_r;
      sec7_r <= sec6_r;
      c7_r   <= c6_r;
      m7_r   <= m6_r;
      x8_r   <= x8_nxt;
      sec8_r <= sec7_r;
      c8_r   <= c7_r;
      m8_r   <= m7_r;
      pix9_r <= pix9_nxt;
    end
  end

  assign out_valid = vld_r[3];
  assign out_pixel = pix9_r;

endmodule

[rtl/core/hsvc_port_checker.sv]
// Port-level checks of the HSV to RGB converter, bound to its top level.
module hsvc_port_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input hsvc_pkg::hsv_t  in_pixel,
  input logic           out_valid,
  input logic           out_stall,
  input hsvc_pkg::rgb_t  out_pixel
);
  import hsvc_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_pixel))
    else $error("stalled input item changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("stalled result item changed or dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel.red <= LVL_W'(LVL_ONE) && out_pixel.green <= LVL_W'(LVL_ONE)
                  && out_pixel.blue <= LVL_W'(LVL_ONE))
    else $error("result component above full scale");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hsv_to_rgb_converter hsvc_port_checker u_hsvc_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_pixel  (in_pixel),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_pixel (out_pixel)
);
